@@ design/mbh_pkg.sv @@
// mbh_pkg: shared types and constants for the multiboot master handshake
// no dependencies; used by every design file and the checker

package mbh_pkg;

    localparam int HDR_IDX_W = 7;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_PALETTE = 2'd0;
    localparam logic [1:0] REG_ROUNDS  = 2'd1;
    localparam logic [1:0] REG_PROBES  = 2'd2;

    localparam logic [7:0] PALETTE_RST = 8'h81;
    localparam logic [7:0] ROUNDS_RST  = 8'd32;
    localparam logic [7:0] PROBES_RST  = 8'd16;

    // status codes
    localparam logic [2:0] ST_BUSY   = 3'd0;
    localparam logic [2:0] ST_READY  = 3'd1;
    localparam logic [2:0] ST_NOSYNC = 3'd2;
    localparam logic [2:0] ST_WRONG  = 3'd3;
    localparam logic [2:0] ST_HEADER = 3'd4;

    // protocol words
    localparam logic [15:0] WORD_PROBE   = 16'h6200;
    localparam logic [15:0] WORD_MASK    = 16'h6100;
    localparam logic [15:0] WORD_PALETTE = 16'h6300;
    localparam logic [15:0] WORD_HSHAKE  = 16'h6400;
    localparam logic [15:0] REPLY_CLIENT = 16'h7200;
    localparam logic [15:0] CLIENT_ID_MASK = 16'hFFF0;
    localparam logic [7:0]  REPLY_PALETTE_HI = 8'h73;

    // handshake byte = 0x11 + 0xff + 0xff + answer, modulo 256
    localparam logic [7:0] HS_OFFSET = 8'((16'h11 + 16'hFF + 16'hFF) & 16'hFF);

    typedef struct packed {
        logic [7:0] palette_byte;
        logic [7:0] discovery_rounds;
        logic [7:0] probes_per_round;
    } cfg_t;

    typedef struct packed {
        logic        func;
        logic [15:0] reply_word;
        logic [15:0] header_half;
    } item_t;

    typedef struct packed {
        logic [15:0] send_word;
        logic        send_valid;
        logic        wait_frame;
        logic [2:0]  status;
        logic [3:0]  clients_found;
        logic [7:0]  client_answer;
        logic [7:0]  handshake_value;
    } result_t;

endpackage

@@ design/mbh_regs.sv @@
// mbh_regs: apb configuration registers (palette byte, round limit, probes per round)
// depends on mbh_pkg

module mbh_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mbh_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mbh_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output mbh_pkg::cfg_t                  cfg
);

    mbh_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.palette_byte     <= mbh_pkg::PALETTE_RST;
            cfg_reg.discovery_rounds <= mbh_pkg::ROUNDS_RST;
            cfg_reg.probes_per_round <= mbh_pkg::PROBES_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                mbh_pkg::REG_PALETTE: cfg_reg.palette_byte     <= pwdata[7:0];
                mbh_pkg::REG_ROUNDS:  cfg_reg.discovery_rounds <= pwdata[7:0];
                mbh_pkg::REG_PROBES:  cfg_reg.probes_per_round <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mbh_pkg::REG_PALETTE: prdata = {24'd0, cfg_reg.palette_byte};
            mbh_pkg::REG_ROUNDS:  prdata = {24'd0, cfg_reg.discovery_rounds};
            mbh_pkg::REG_PROBES:  prdata = {24'd0, cfg_reg.probes_per_round};
            default:              prdata = '0;
        endcase
    end

endmodule

@@ design/mbh_seq.sv @@
// mbh_seq: handshake phase sequencer; holds the exchange state and forms each result
// depends on mbh_pkg

module mbh_seq #(
    parameter int HEADER_HALVES = 96
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  mbh_pkg::item_t   item,
    input  mbh_pkg::cfg_t    cfg,
    output mbh_pkg::result_t result
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_DISC    = 3'd1;
    localparam logic [2:0] PH_MASKCHK = 3'd2;
    localparam logic [2:0] PH_HEADER  = 3'd3;
    localparam logic [2:0] PH_CONF1   = 3'd4;
    localparam logic [2:0] PH_CONF2   = 3'd5;
    localparam logic [2:0] PH_PALETTE = 3'd6;
    localparam logic [2:0] PH_HSHAKE  = 3'd7;

    localparam logic [7:0] HDR_COUNT = 8'(HEADER_HALVES);

    logic [2:0]                      phase_reg, phase_next;
    logic [7:0]                      round_count_reg, round_count_next;
    logic [7:0]                      probe_count_reg, probe_count_next;
    logic [3:0]                      client_mask_reg, client_mask_next;
    logic [mbh_pkg::HDR_IDX_W-1:0]   header_index_reg, header_index_next;
    logic [7:0]                      answer_byte_reg, answer_byte_next;
    logic [7:0]                      handshake_byte_reg, handshake_byte_next;

    logic [7:0]                      probe_inc;
    logic [7:0]                      round_inc;
    logic [mbh_pkg::HDR_IDX_W-1:0]   index_inc;
    logic [3:0]                      mask_seen;
    logic [15:0]                     countdown;
    logic [15:0]                     word;
    logic                            word_valid;
    logic                            wait_flag;
    logic [2:0]                      status;

    assign probe_inc = probe_count_reg + 8'd1;
    assign round_inc = round_count_reg + 8'd1;
    assign index_inc = header_index_reg + 1'b1;
    assign mask_seen = ((item.reply_word & mbh_pkg::CLIENT_ID_MASK) == mbh_pkg::REPLY_CLIENT)
                       ? (client_mask_reg | item.reply_word[3:0]) : client_mask_reg;
    // expected countdown reply during the header
    assign countdown = {8'(HDR_COUNT - {1'b0, header_index_reg}), 4'd0, client_mask_reg};

    always_comb
    begin
        phase_next          = phase_reg;
        round_count_next    = round_count_reg;
        probe_count_next    = probe_count_reg;
        client_mask_next    = client_mask_reg;
        header_index_next   = header_index_reg;
        answer_byte_next    = answer_byte_reg;
        handshake_byte_next = handshake_byte_reg;
        word       = 16'd0;
        word_valid = 1'b0;
        wait_flag  = 1'b0;
        status     = mbh_pkg::ST_BUSY;

        if (!item.func)
        begin
            phase_next          = PH_DISC;
            round_count_next    = 8'd0;
            probe_count_next    = 8'd0;
            client_mask_next    = 4'd0;
            header_index_next   = '0;
            answer_byte_next    = 8'd0;
            handshake_byte_next = 8'd0;
            word       = mbh_pkg::WORD_PROBE;
            word_valid = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_DISC:
                begin
                    client_mask_next = mask_seen;
                    if (probe_inc < cfg.probes_per_round)
                    begin
                        probe_count_next = probe_inc;
                        word       = mbh_pkg::WORD_PROBE;
                        word_valid = 1'b1;
                    end
                    else
                    begin
                        probe_count_next = 8'd0;
                        if (mask_seen != 4'd0)
                        begin
                            phase_next = PH_MASKCHK;
                            word       = mbh_pkg::WORD_MASK | {12'd0, mask_seen};
                            word_valid = 1'b1;
                        end
                        else
                        begin
                            round_count_next = round_inc;
                            if (round_inc >= cfg.discovery_rounds)
                            begin
                                phase_next = PH_IDLE;
                                status     = mbh_pkg::ST_NOSYNC;
                            end
                            else
                            begin
                                word       = mbh_pkg::WORD_PROBE;
                                word_valid = 1'b1;
                                wait_flag  = 1'b1;
                            end
                        end
                    end
                end
                PH_MASKCHK:
                begin
                    if (item.reply_word != (mbh_pkg::REPLY_CLIENT | {12'd0, client_mask_reg}))
                    begin
                        phase_next = PH_IDLE;
                        status     = mbh_pkg::ST_WRONG;
                    end
                    else
                    begin
                        phase_next        = PH_HEADER;
                        header_index_next = '0;
                        word       = item.header_half;
                        word_valid = 1'b1;
                    end
                end
                PH_HEADER:
                begin
                    if (item.reply_word != countdown)
                    begin
                        phase_next = PH_IDLE;
                        status     = mbh_pkg::ST_HEADER;
                    end
                    else
                    begin
                        header_index_next = index_inc;
                        if ({1'b0, index_inc} < HDR_COUNT)
                        begin
                            word       = item.header_half;
                            word_valid = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CONF1;
                            word       = mbh_pkg::WORD_PROBE;
                            word_valid = 1'b1;
                        end
                    end
                end
                PH_CONF1:
                begin
                    if (item.reply_word != {12'd0, client_mask_reg})
                    begin
                        phase_next = PH_IDLE;
                        status     = mbh_pkg::ST_WRONG;
                    end
                    else
                    begin
                        phase_next = PH_CONF2;
                        word       = mbh_pkg::WORD_PROBE | {12'd0, client_mask_reg};
                        word_valid = 1'b1;
                    end
                end
                PH_CONF2:
                begin
                    if (item.reply_word != (mbh_pkg::REPLY_CLIENT | {12'd0, client_mask_reg}))
                    begin
                        phase_next = PH_IDLE;
                        status     = mbh_pkg::ST_WRONG;
                    end
                    else
                    begin
                        phase_next = PH_PALETTE;
                        word       = mbh_pkg::WORD_PALETTE | {8'd0, cfg.palette_byte};
                        word_valid = 1'b1;
                    end
                end
                PH_PALETTE:
                begin
                    if (item.reply_word[15:8] != mbh_pkg::REPLY_PALETTE_HI)
                    begin
                        word       = mbh_pkg::WORD_PALETTE | {8'd0, cfg.palette_byte};
                        word_valid = 1'b1;
                    end
                    else
                    begin
                        answer_byte_next    = item.reply_word[7:0];
                        handshake_byte_next = item.reply_word[7:0] + mbh_pkg::HS_OFFSET;
                        phase_next = PH_HSHAKE;
                        word       = mbh_pkg::WORD_HSHAKE
                                     | {8'd0, item.reply_word[7:0] + mbh_pkg::HS_OFFSET};
                        word_valid = 1'b1;
                    end
                end
                PH_HSHAKE:
                begin
                    phase_next = PH_IDLE;
                    status     = (item.reply_word[15:8] != mbh_pkg::REPLY_PALETTE_HI)
                                 ? mbh_pkg::ST_WRONG : mbh_pkg::ST_READY;
                end
                default: ;  // idle: reply ignored
            endcase
        end

        result.send_word       = word;
        result.send_valid      = word_valid;
        result.wait_frame      = wait_flag;
        result.status          = status;
        result.clients_found   = client_mask_next;
        result.client_answer   = answer_byte_next;
        result.handshake_value = handshake_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            round_count_reg    <= 8'd0;
            probe_count_reg    <= 8'd0;
            client_mask_reg    <= 4'd0;
            header_index_reg   <= '0;
            answer_byte_reg    <= 8'd0;
            handshake_byte_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            round_count_reg    <= round_count_next;
            probe_count_reg    <= probe_count_next;
            client_mask_reg    <= client_mask_next;
            header_index_reg   <= header_index_next;
            answer_byte_reg    <= answer_byte_next;
            handshake_byte_reg <= handshake_byte_next;
        end
    end

endmodule

@@ design/multiboot_master_handshake.sv @@
// multiboot_master_handshake: top level; input register, sequencer, result register, apb port
// depends on mbh_pkg, mbh_regs, mbh_seq

// Master-side sequencer for a serial multiboot handshake. Push a word with func=0 to start
// (the result asks for the first probe 0x6200); after each exchange push func=1 with the
// 16-bit reply and the next header halfword. Every input word gives exactly one result word
// carrying the next word to transmit (send_word/send_valid), a frame-wait flag, a status code
// and the current client mask, palette answer and handshake byte. A status other than busy
// means the handshake ended; the block then idles until the next start. Throughput is one
// word per clock while the output side is not stalled: a word waits in the input register,
// the sequencer decides the phase update and the reply in a single pass, and the result
// sits in an output register, which out_valid marks as full. in_stall rises only when the
// input register holds a word that cannot move because the output register is full and
// stalled. Configuration (palette byte, round limit, probes per round) sits on an APB port
// at byte addresses 0x0, 0x4, 0x8 and should be written only while no word is in flight.

module multiboot_master_handshake #(
    parameter int HEADER_HALVES = 96
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [15:0] reply_word,
    input  logic [15:0] header_half,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] send_word,
    output logic        send_valid,
    output logic        wait_frame,
    output logic [2:0]  status,
    output logic [3:0]  clients_found,
    output logic [7:0]  client_answer,
    output logic [7:0]  handshake_value,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mbh_pkg::cfg_t    cfg;
    mbh_pkg::item_t   item_reg;
    mbh_pkg::result_t result;
    mbh_pkg::result_t out_reg;
    logic             item_valid_reg;
    logic             out_valid_reg;
    logic             advance;    // word in the input register moves to the output register
    logic             in_accept;

    mbh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbh_seq #(
        .HEADER_HALVES (HEADER_HALVES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // output register free when empty or being taken this cycle
    assign advance   = item_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = item_valid_reg & ~advance;
    assign in_accept = in_valid & ~in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.func        <= func;
            item_reg.reply_word  <= reply_word;
            item_reg.header_half <= header_half;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign send_word       = out_reg.send_word;
    assign send_valid      = out_reg.send_valid;
    assign wait_frame      = out_reg.wait_frame;
    assign status          = out_reg.status;
    assign clients_found   = out_reg.clients_found;
    assign client_answer   = out_reg.client_answer;
    assign handshake_value = out_reg.handshake_value;

endmodule

@@ design/mbh_check.sv @@
// mbh_check: port-level checks on the multiboot master handshake results
// depends on mbh_pkg; bound to multiboot_master_handshake

module mbh_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] send_word,
    input logic        send_valid,
    input logic        wait_frame,
    input logic [2:0]  status,
    input logic [7:0]  client_answer,
    input logic [7:0]  handshake_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(send_word) && $stable(status))
        else $error("stalled result changed");

    // nothing to send means a zero word
    a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_valid |-> send_word == 16'd0)
        else $error("send_word nonzero without send_valid");

    // a finished handshake sends nothing
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != mbh_pkg::ST_BUSY |-> !send_valid && !wait_frame)
        else $error("word sent with final status");

    // frame wait only between discovery rounds
    a_wait_probe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wait_frame |-> send_valid && send_word == mbh_pkg::WORD_PROBE)
        else $error("frame wait on a word other than a probe");

    // success carries the handshake byte derived from the answer
    a_ready_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mbh_pkg::ST_READY
            |-> handshake_value == 8'(client_answer + mbh_pkg::HS_OFFSET))
        else $error("handshake byte does not match client answer");

endmodule

bind multiboot_master_handshake mbh_check u_mbh_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .send_word       (send_word),
    .send_valid      (send_valid),
    .wait_frame      (wait_frame),
    .status          (status),
    .client_answer   (client_answer),
    .handshake_value (handshake_value)
);

@@ bench/testbench.sv @@
// testbench: self-checking bench for the multiboot master handshake sequencer
// drives random and directed handshakes, checks every result word against its own predictor
// depends on mbh_pkg and multiboot_master_handshake

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_HALVES = 96;
    localparam int RANDOM_ITEMS = 1900;
    // worst case is a few thousand words, each with two full gaps, plus register traffic
    localparam int CYCLE_LIMIT = 800000;

    // sequencer phases as the predictor tracks them
    typedef enum logic [2:0] {
        P_IDLE,
        P_DISCOVER,
        P_MASKCHK,
        P_HEADER,
        P_CONF1,
        P_CONF2,
        P_PALETTE,
        P_HSHAKE
    } hs_phase_t;

    // predictor of the handshake sequencer plus the queue of result words it owes
    class handshake_predictor;
        mbh_pkg::cfg_t    cfg;
        hs_phase_t        phase;
        logic [7:0]       rounds_done;
        logic [7:0]       probes_done;
        logic [3:0]       mask;
        logic [6:0]       hdr_idx;
        logic [7:0]       answer;
        logic [7:0]       hs_byte;
        mbh_pkg::result_t expected_words[$];
        int               errors;

        function new();
            cfg.palette_byte = mbh_pkg::PALETTE_RST;
            cfg.discovery_rounds = mbh_pkg::ROUNDS_RST;
            cfg.probes_per_round = mbh_pkg::PROBES_RST;
            phase = P_IDLE;
            rounds_done = '0;
            probes_done = '0;
            mask = '0;
            hdr_idx = '0;
            answer = '0;
            hs_byte = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                mbh_pkg::REG_PALETTE: cfg.palette_byte = v;
                mbh_pkg::REG_ROUNDS:  cfg.discovery_rounds = v;
                mbh_pkg::REG_PROBES:  cfg.probes_per_round = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void owe(logic [15:0] word, logic valid, logic wait_f, logic [2:0] st);
            mbh_pkg::result_t r;
            r.send_word = valid ? word : 16'h0000;
            r.send_valid = valid;
            r.wait_frame = wait_f;
            r.status = st;
            r.clients_found = mask;
            r.client_answer = answer;
            r.handshake_value = hs_byte;
            expected_words.push_back(r);
        endfunction

        function void conclude(logic [2:0] st);
            phase = P_IDLE;
            owe(16'h0000, 1'b0, 1'b0, st);
        endfunction

        // one accepted input word: advance the phase and queue the word the block must answer
        function void note_sent(logic f, logic [15:0] reply, logic [15:0] half);
            logic [15:0] want;
            if (!f)
            begin
                phase = P_DISCOVER;
                rounds_done = '0;
                probes_done = '0;
                mask = '0;
                hdr_idx = '0;
                answer = '0;
                hs_byte = '0;
                owe(mbh_pkg::WORD_PROBE, 1'b1, 1'b0, mbh_pkg::ST_BUSY);
            end
            else
            begin
                case (phase)
                    P_DISCOVER:
                    begin
                        if ((reply & mbh_pkg::CLIENT_ID_MASK) == mbh_pkg::REPLY_CLIENT)
                            mask = mask | reply[3:0];
                        probes_done = probes_done + 8'd1;
                        if (probes_done < cfg.probes_per_round)
                        begin
                            owe(mbh_pkg::WORD_PROBE, 1'b1, 1'b0, mbh_pkg::ST_BUSY);
                        end
                        else
                        begin
                            probes_done = '0;
                            if (mask != 4'h0)
                            begin
                                phase = P_MASKCHK;
                                owe(mbh_pkg::WORD_MASK | {12'h000, mask}, 1'b1, 1'b0,
                                    mbh_pkg::ST_BUSY);
                            end
                            else
                            begin
                                rounds_done = rounds_done + 8'd1;
                                if (rounds_done >= cfg.discovery_rounds)
                                    conclude(mbh_pkg::ST_NOSYNC);
                                else
                                    owe(mbh_pkg::WORD_PROBE, 1'b1, 1'b1, mbh_pkg::ST_BUSY);
                            end
                        end
                    end
                    P_MASKCHK:
                    begin
                        if (reply != (mbh_pkg::REPLY_CLIENT | {12'h000, mask}))
                        begin
                            conclude(mbh_pkg::ST_WRONG);
                        end
                        else
                        begin
                            phase = P_HEADER;
                            hdr_idx = '0;
                            owe(half, 1'b1, 1'b0, mbh_pkg::ST_BUSY);
                        end
                    end
                    P_HEADER:
                    begin
                        want = {8'(HDR_HALVES - int'(hdr_idx)), 4'h0, mask};
                        if (reply != want)
                        begin
                            conclude(mbh_pkg::ST_HEADER);
                        end
                        else
                        begin
                            hdr_idx = hdr_idx + 7'd1;
                            if (int'(hdr_idx) < HDR_HALVES)
                            begin
                                owe(half, 1'b1, 1'b0, mbh_pkg::ST_BUSY);
                            end
                            else
                            begin
                                phase = P_CONF1;
                                owe(mbh_pkg::WORD_PROBE, 1'b1, 1'b0, mbh_pkg::ST_BUSY);
                            end
                        end
                    end
                    P_CONF1:
                    begin
                        if (reply != {12'h000, mask})
                        begin
                            conclude(mbh_pkg::ST_WRONG);
                        end
                        else
                        begin
                            phase = P_CONF2;
                            owe(mbh_pkg::WORD_PROBE | {12'h000, mask}, 1'b1, 1'b0,
                                mbh_pkg::ST_BUSY);
                        end
                    end
                    P_CONF2:
                    begin
                        if (reply != (mbh_pkg::REPLY_CLIENT | {12'h000, mask}))
                        begin
                            conclude(mbh_pkg::ST_WRONG);
                        end
                        else
                        begin
                            phase = P_PALETTE;
                            owe(mbh_pkg::WORD_PALETTE | {8'h00, cfg.palette_byte}, 1'b1, 1'b0,
                                mbh_pkg::ST_BUSY);
                        end
                    end
                    P_PALETTE:
                    begin
                        if (reply[15:8] != mbh_pkg::REPLY_PALETTE_HI)
                        begin
                            owe(mbh_pkg::WORD_PALETTE | {8'h00, cfg.palette_byte}, 1'b1, 1'b0,
                                mbh_pkg::ST_BUSY);
                        end
                        else
                        begin
                            answer = reply[7:0];
                            hs_byte = 8'h11 + 8'hFF + 8'hFF + answer;
                            phase = P_HSHAKE;
                            owe(mbh_pkg::WORD_HSHAKE | {8'h00, hs_byte}, 1'b1, 1'b0,
                                mbh_pkg::ST_BUSY);
                        end
                    end
                    P_HSHAKE:
                    begin
                        if (reply[15:8] != mbh_pkg::REPLY_PALETTE_HI)
                            conclude(mbh_pkg::ST_WRONG);
                        else
                            conclude(mbh_pkg::ST_READY);
                    end
                    default: owe(16'h0000, 1'b0, 1'b0, mbh_pkg::ST_BUSY);
                endcase
            end
        endfunction

        function void flag(string what, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, exp, act);
            end
        endfunction

        function void check_received(mbh_pkg::result_t got);
            mbh_pkg::result_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t ns: result word with nothing expected, %s 0x%0h",
                         $time, "expected none, actual", got);
            end
            else
            begin
                want = expected_words.pop_front();
                flag("send_word", want.send_word, got.send_word);
                flag("send_valid", 16'(want.send_valid), 16'(got.send_valid));
                flag("wait_frame", 16'(want.wait_frame), 16'(got.wait_frame));
                flag("status", 16'(want.status), 16'(got.status));
                flag("clients_found", 16'(want.clients_found), 16'(got.clients_found));
                flag("client_answer", 16'(want.client_answer), 16'(got.client_answer));
                flag("handshake_value", 16'(want.handshake_value), 16'(got.handshake_value));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = 1'b0;
    logic [15:0] reply_word = 16'h0000;
    logic [15:0] header_half = 16'h0000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] send_word;
    logic        send_valid;
    logic        wait_frame;
    logic [2:0]  status;
    logic [3:0]  clients_found;
    logic [7:0]  client_answer;
    logic [7:0]  handshake_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    handshake_predictor sb = new();

    // stimulus bookkeeping
    bit calm = 1'b1;          // when set neither side inserts random gaps (a sender pause still does)
    int client_pct = 30;      // chance that a discovery reply carries client bits
    int words_pushed = 0;
    int random_items = 0;
    int pauses = 0;
    longint cycles = 0;

    multiboot_master_handshake #(
        .HEADER_HALVES(HDR_HALVES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .reply_word(reply_word),
        .header_half(header_half),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .send_word(send_word),
        .send_valid(send_valid),
        .wait_frame(wait_frame),
        .status(status),
        .clients_found(clients_found),
        .client_answer(client_answer),
        .handshake_value(handshake_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost word ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // gap before a word or before taking a result; calm stretches have none
    function automatic int draw_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 3);
        if (r == 0)
            return $urandom_range(0, 17);
        else if (r == 1)
            return $urandom_range(0, 2);
        return 0;
    endfunction

    // result monitor: a word moves at an edge with out_valid high and out_stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_received({send_word, send_valid, wait_frame, status,
                               clients_found, client_answer, handshake_value});
    end

    // receiver: holds stall for a random number of cycles before each result word
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = draw_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // send one input word; the predictor learns it at the edge where it is taken
    task automatic push_word(logic f, logic [15:0] r, logic [15:0] h);
        int gap;
        bit hold;
        gap = draw_gap();
        // sender pause: let every owed result drain before the next word
        hold = (pauses == 0 && words_pushed == 60) || ($urandom_range(0, 399) == 0);
        // a pause always drops valid before the next word
        if (hold && gap == 0)
            gap = 1;
        if (gap > 0)
            in_valid <= 1'b0;
        if (hold)
        begin
            pauses++;
            while (sb.pending() != 0) @(posedge clk);
        end
        if (gap > 0)
            repeat (gap) @(posedge clk);
        func <= f;
        reply_word <= r;
        header_half <= h;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_sent(f, r, h);
        words_pushed++;
    endtask

    // apb write followed by a read back of the same register
    task automatic program_reg(logic [1:0] idx, logic [7:0] v);
        logic [31:0] wdata;
        wdata = $urandom;
        wdata[7:0] = v;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        sb.set_reg(idx, v);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== v)
        begin
            sb.errors++;
            $display("%0t ns: register %0d read back, expected 0x%0h, actual 0x%0h",
                     $time, idx, v, prdata[7:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // drain the block, let the pipeline empty, then load all three registers
    task automatic set_config(logic [7:0] pal, logic [7:0] rounds, logic [7:0] probes);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        program_reg(mbh_pkg::REG_PALETTE, pal);
        program_reg(mbh_pkg::REG_ROUNDS, rounds);
        program_reg(mbh_pkg::REG_PROBES, probes);
    endtask

    // reply a client would give to the last word sent; slips are single-bit near misses
    function automatic logic [15:0] pick_reply(int slip_pct, int hdr_slip_pm);
        logic [15:0] good;
        logic [15:0] r;
        bit ok;
        ok = ($urandom_range(0, 99) >= slip_pct);
        r = 16'($urandom);
        case (sb.phase)
            P_DISCOVER:
            begin
                if ($urandom_range(0, 99) < client_pct)
                    r = mbh_pkg::REPLY_CLIENT | 16'($urandom_range(0, 15));
                return r;
            end
            P_MASKCHK: good = mbh_pkg::REPLY_CLIENT | {12'h000, sb.mask};
            P_HEADER:
            begin
                good = {8'(HDR_HALVES - int'(sb.hdr_idx)), 4'h0, sb.mask};
                ok = ($urandom_range(0, 999) >= hdr_slip_pm);
            end
            P_CONF1: good = {12'h000, sb.mask};
            P_CONF2: good = mbh_pkg::REPLY_CLIENT | {12'h000, sb.mask};
            P_PALETTE:
            begin
                // client keeps the master waiting for a few rounds of palette commands
                if ($urandom_range(0, 99) < 40)
                begin
                    r[15:8] = mbh_pkg::REPLY_PALETTE_HI;
                end
                else if (r[15:8] == mbh_pkg::REPLY_PALETTE_HI)
                begin
                    r[15:8] = 8'h00;
                end
                return r;
            end
            P_HSHAKE:
            begin
                good = {mbh_pkg::REPLY_PALETTE_HI, 8'($urandom)};
                if (!ok)
                    good[15:8] = good[15:8] ^ (8'h01 << $urandom_range(0, 7));
                return good;
            end
            default: return r;
        endcase
        if (!ok)
            good = good ^ (16'h0001 << $urandom_range(0, 15));
        return good;
    endfunction

    // one handshake from start to an end status, with occasional restarts
    task automatic run_session();
        int n;
        int slip_pct;
        int hdr_slip_pm;
        n = 0;
        case ($urandom_range(0, 3))
            0: slip_pct = 3;
            1: slip_pct = 20;
            default: slip_pct = 0;
        endcase
        case ($urandom_range(0, 3))
            0: hdr_slip_pm = 2;
            1: hdr_slip_pm = 10;
            default: hdr_slip_pm = 0;
        endcase
        push_word(1'b0, 16'($urandom), 16'($urandom));
        random_items++;
        while (sb.phase != P_IDLE && n < 1500 && random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 499) == 0)
                push_word(1'b0, 16'($urandom), 16'($urandom));
            else
                push_word(1'b1, pick_reply(slip_pct, hdr_slip_pm), 16'($urandom));
            n++;
            random_items++;
        end
        // stray reply while idle, the block just answers with nothing to send
        if ($urandom_range(0, 3) == 0)
            push_word(1'b1, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int sess;
        int space;
        logic [7:0] pal;
        logic [7:0] rounds;
        logic [7:0] probes;

        // reset held low from time zero, released on a rising edge
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // reply with no handshake running
        push_word(1'b1, 16'hFFFF, 16'hFFFF);
        set_config(8'hFF, 8'd1, 8'd1);
        // start, then a second start while busy
        push_word(1'b0, 16'hFFFF, 16'hFFFF);
        push_word(1'b0, 16'h0000, 16'h0000);
        // no client in the only round
        push_word(1'b1, 16'h0000, 16'h0000);
        // client found, wrong mask confirmation
        push_word(1'b0, 16'h0000, 16'h0000);
        push_word(1'b1, 16'h720F, 16'hA5A5);
        push_word(1'b1, 16'h720E, 16'h5A5A);
        // header error on the first countdown reply
        push_word(1'b0, 16'h0000, 16'h0000);
        push_word(1'b1, 16'h7203, 16'hFFFF);
        push_word(1'b1, 16'h7203, 16'h1234);
        push_word(1'b1, 16'h0003, 16'h0000);
        // zero rounds and zero probes behave as one
        set_config(8'h00, 8'd0, 8'd0);
        push_word(1'b0, 16'h0000, 16'h0000);
        push_word(1'b1, 16'h1234, 16'h0000);
        push_word(1'b0, 16'h0000, 16'h0000);
        push_word(1'b1, 16'h7201, 16'h0000);
        // empty first round then a frame wait before the second
        set_config(8'h00, 8'd2, 8'd1);
        push_word(1'b0, 16'h0000, 16'h0000);
        push_word(1'b1, 16'hFFFF, 16'h0000);
        push_word(1'b1, 16'h7208, 16'h0000);
        push_word(1'b1, 16'h7208, 16'hFFFF);

        // ---------------- random part ----------------
        sess = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (sess == 0)
            begin
                set_config(mbh_pkg::PALETTE_RST, mbh_pkg::ROUNDS_RST, mbh_pkg::PROBES_RST);
            end
            else if (sess % 3 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pal = 8'h00;
                    1: pal = 8'hFF;
                    default: pal = 8'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0: rounds = 8'd0;
                    1: rounds = 8'd1;
                    2: rounds = 8'd255;
                    3: rounds = 8'd2;
                    default: rounds = 8'($urandom_range(1, 255));
                endcase
                case ($urandom_range(0, 7))
                    0: probes = 8'd0;
                    1: probes = 8'd255;
                    2: probes = 8'd16;
                    default: probes = 8'($urandom_range(1, 8));
                endcase
                set_config(pal, rounds, probes);
            end
            // a discovery that may never find a client only where it stays short
            space = (sb.cfg.discovery_rounds == 0 ? 1 : int'(sb.cfg.discovery_rounds)) *
                    (sb.cfg.probes_per_round == 0 ? 1 : int'(sb.cfg.probes_per_round));
            if (space <= 48 && $urandom_range(0, 3) == 0)
                client_pct = 0;
            else
                client_pct = $urandom_range(5, 60);
            calm = ($urandom_range(0, 3) == 0);
            run_session();
            sess++;
        end

        // ---------------- drain and report ----------------
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
